// ----- rtl/core/imsu_pkg.sv -----
package imsu_pkg;

    localparam int COORD_W = 6;
    localparam int COORD_N = 1 << COORD_W;
    localparam int FRAC_W  = 32;
    localparam int DE_W    = 5;
    localparam int CFG_IDX_W = 2;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_DE4 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH_DE8 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FREEZE     = CFG_IDX_W'(2);

    localparam logic signed [DE_W-1:0] DE_ZERO  = DE_W'(0);
    localparam logic signed [DE_W-1:0] DE_PLUS4 = DE_W'(4);
    localparam logic signed [DE_W-1:0] DE_PLUS8 = DE_W'(8);

    typedef struct packed {
        logic [FRAC_W-1:0] thresh_de4;
        logic [FRAC_W-1:0] thresh_de8;
        logic              freeze;
    } t_cfg;

    typedef struct packed {
        logic                   spin;
        logic                   flipped;
        logic signed [DE_W-1:0] energy_change;
    } t_eval_res;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_ROW   = 4'b0100,
        S_EVAL  = 4'b1000
    } t_state;

endpackage

// ----- rtl/core/imsu_ram.sv -----
module imsu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/imsu_site_eval.sv -----
module imsu_site_eval (
    input  imsu_pkg::t_cfg                  i_cfg,
    input  imsu_pkg::t_cmd                  i_command,
    input  logic [imsu_pkg::FRAC_W-1:0]     i_uniform,
    input  logic                            i_centre,
    input  logic                            i_up,
    input  logic                            i_dn,
    input  logic                            i_lf,
    input  logic                            i_rt,
    output imsu_pkg::t_eval_res             o_res
);
    import imsu_pkg::*;

    logic [2:0]             w_ups;
    logic signed [DE_W:0]   w_de_pos;
    logic signed [DE_W:0]   w_de_wide;
    logic signed [DE_W-1:0] w_de;
    logic                   w_accept;
    logic                   w_flip;

    assign w_ups = {2'b00, i_up} + {2'b00, i_dn} + {2'b00, i_lf} + {2'b00, i_rt};

    // dE for a +1 centre is 4*ups - 8, negated for a -1 centre
    assign w_de_pos  = $signed({1'b0, w_ups, 2'b00}) - $signed((DE_W+1)'(8));
    assign w_de_wide = i_centre ? w_de_pos : -w_de_pos;
    assign w_de      = w_de_wide[DE_W-1:0];

    always_comb begin
        priority if (w_de[DE_W-1] || (w_de == DE_ZERO)) begin
            w_accept = 1'b1;
        end else if (w_de == DE_PLUS4) begin
            w_accept = i_uniform < i_cfg.thresh_de4;
        end else begin
            w_accept = i_uniform < i_cfg.thresh_de8;
        end
    end

    assign w_flip = !i_cfg.freeze && w_accept;

    always_comb begin
        unique case (i_command)
            CMD_READ: begin
                o_res.spin          = i_centre;
                o_res.flipped       = 1'b0;
                o_res.energy_change = DE_ZERO;
            end
            CMD_UPDATE: begin
                o_res.spin          = i_centre ^ w_flip;
                o_res.flipped       = w_flip;
                o_res.energy_change = w_de;
            end
            default: begin
                o_res.spin          = i_centre;
                o_res.flipped       = 1'b0;
                o_res.energy_change = DE_ZERO;
            end
        endcase
    end

endmodule

// ----- rtl/core/ising_metropolis_spin_update_core.sv -----
// Metropolis single-spin-flip engine for a SIDE x SIDE Ising lattice with periodic wrap.
// The lattice is kept as two identical copies of a SIDE-row memory, one row of SIDE spins
// per word. For each item the rows above and below are read together (one per copy),
// then the centre row, then dE and the flip decision are formed and the centre row
// is written back to both copies while the result beat is loaded into the output register.
// The next item is taken while that result still waits. After reset a clearing pass
// sets every spin to +1; no item is accepted until it ends. Configuration writes
// are taken at any time.
module ising_metropolis_spin_update_core #(
    parameter int SIDE = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [imsu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [imsu_pkg::FRAC_W-1:0]          i_cfg_data,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_command,
    input  logic [imsu_pkg::COORD_W-1:0]         i_row,
    input  logic [imsu_pkg::COORD_W-1:0]         i_col,
    input  logic [imsu_pkg::FRAC_W-1:0]          i_uniform,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_spin,
    output logic                                 o_flipped,
    output logic signed [imsu_pkg::DE_W-1:0]     o_energy_change
);
    import imsu_pkg::*;

    localparam int CW = $clog2(SIDE);
    localparam logic [CW-1:0] LAST = CW'(SIDE - 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_clr_cnt;
    t_cfg          r_cfg;

    t_cmd              r_command;
    logic [CW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [FRAC_W-1:0] r_uniform;
    logic [SIDE-1:0]   r_up_row;
    logic [SIDE-1:0]   r_dn_row;

    logic                   r_out_valid;
    logic                   r_spin;
    logic                   r_flipped;
    logic signed [DE_W-1:0] r_de;

    logic [CW-1:0]   w_mod_tab [COORD_N];
    logic [CW-1:0]   w_in_row;
    logic [CW-1:0]   w_in_up;
    logic [CW-1:0]   w_in_dn;
    logic [CW-1:0]   w_col_lf;
    logic [CW-1:0]   w_col_rt;
    logic [CW-1:0]   w_raddr_a;
    logic [CW-1:0]   w_raddr_b;
    logic [CW-1:0]   w_waddr;
    logic [SIDE-1:0] w_wdata;
    logic [SIDE-1:0] w_rdata_a;
    logic [SIDE-1:0] w_rdata_b;
    logic            w_we;
    logic            w_in_fire;
    logic            w_eval_fire;
    t_eval_res       w_res;

    // coordinate reduction modulo SIDE as a constant table
    for (genvar k = 0; k < COORD_N; k++) begin : g_mod
        assign w_mod_tab[k] = CW'(k % SIDE);
    end

    assign w_in_row = w_mod_tab[i_row];
    assign w_in_up  = (w_in_row == '0) ? LAST : w_in_row - CW'(1);
    assign w_in_dn  = (w_in_row == LAST) ? '0 : w_in_row + CW'(1);
    assign w_col_lf = (r_col == '0) ? LAST : r_col - CW'(1);
    assign w_col_rt = (r_col == LAST) ? '0 : r_col + CW'(1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_eval_fire = (r_state == S_EVAL) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_cnt == LAST) n_state = S_IDLE;
            S_IDLE:  if (w_in_fire) n_state = S_ROW;
            S_ROW:   n_state = S_EVAL;
            S_EVAL:  if (w_eval_fire) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // copy a serves the upper and then the centre row, copy b the lower row
    assign w_raddr_a = (r_state == S_IDLE) ? w_in_up : r_row;
    assign w_raddr_b = w_in_dn;

    always_comb begin
        w_wdata = w_rdata_a;
        w_wdata[r_col] = w_res.spin;
        if (r_state == S_CLEAR) begin
            w_wdata = '1;
        end
    end

    assign w_we    = (r_state == S_CLEAR) || w_eval_fire;
    assign w_waddr = (r_state == S_CLEAR) ? r_clr_cnt : r_row;

    imsu_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    imsu_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    imsu_site_eval u_eval (
        .i_cfg     (r_cfg),
        .i_command (r_command),
        .i_uniform (r_uniform),
        .i_centre  (w_rdata_a[r_col]),
        .i_up      (r_up_row[r_col]),
        .i_dn      (r_dn_row[r_col]),
        .i_lf      (w_rdata_a[w_col_lf]),
        .i_rt      (w_rdata_a[w_col_rt]),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_cfg       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + CW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_THRESH_DE4: r_cfg.thresh_de4 <= i_cfg_data;
                    CFG_THRESH_DE8: r_cfg.thresh_de8 <= i_cfg_data;
                    CFG_FREEZE:     r_cfg.freeze     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_eval_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_command <= t_cmd'(i_command);
            r_row     <= w_in_row;
            r_col     <= w_mod_tab[i_col];
            r_uniform <= i_uniform;
        end
        if (r_state == S_ROW) begin
            r_up_row <= w_rdata_a;
            r_dn_row <= w_rdata_b;
        end
        if (w_eval_fire) begin
            r_spin    <= w_res.spin;
            r_flipped <= w_res.flipped;
            r_de      <= w_res.energy_change;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_spin          = r_spin;
    assign o_flipped       = r_flipped;
    assign o_energy_change = r_de;

endmodule
